### sv/minterm_area_blitter_top_defines.svh
// Assertion macros shared by the blitter RTL.
// Both expect signals named clock and reset in the calling scope.
`ifndef MINTERM_AREA_BLITTER_TOP_DEFINES_SVH
`define MINTERM_AREA_BLITTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define MAB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MAB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/mab_pkg.sv
package mab_pkg;

   localparam int ADDR_BITS     = 18;
   localparam int WORD_BITS     = 16;
   localparam int CODE_BITS     = 8;
   localparam int SHIFT_BITS    = 4;
   localparam int WIDTH_BITS    = 7;
   localparam int HEIGHT_BITS   = 11;
   localparam int MODULO_BITS   = 13;
   localparam int COL_BITS      = 6;
   localparam int ROW_BITS      = 10;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = ADDR_BITS;

   // register map
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MINTERM_CODE = 3'd0,
      CSR_A_SHIFT      = 3'd1,
      CSR_WIDTH_WORDS  = 3'd2,
      CSR_HEIGHT_ROWS  = 3'd3,
      CSR_DEST_START   = 3'd4,
      CSR_DEST_MODULO  = 3'd5
   } csr_index_type;

   localparam logic [CODE_BITS-1:0]   MINTERM_RESET = 8'hF0;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET   = 7'd20;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET  = 11'd256;

   typedef struct packed {
      logic [CODE_BITS-1:0]          minterm_code;
      logic [SHIFT_BITS-1:0]         a_shift;
      logic [WIDTH_BITS-1:0]         width_words;
      logic [HEIGHT_BITS-1:0]        height_rows;
      logic [ADDR_BITS-1:0]          dest_start;
      logic signed [MODULO_BITS-1:0] dest_modulo;
   } cfg_type;

   // per-item tag from the sequencer into the datapath
   typedef struct packed {
      logic [WORD_BITS-1:0] prev_a;
      logic [ADDR_BITS-1:0] address;
      logic                 row_end;
      logic                 area_end;
   } seq_type;

   // A shifted right with the previous A word's low bits entering at the top
   function automatic logic [WORD_BITS-1:0] shift_a(
      input logic [WORD_BITS-1:0]  prev_a,
      input logic [WORD_BITS-1:0]  a,
      input logic [SHIFT_BITS-1:0] amount
   );
      logic [2*WORD_BITS-1:0] joined;
      joined = {prev_a, a} >> amount;
      return joined[WORD_BITS-1:0];
   endfunction

   // sum of the product terms chosen by the truth table
   function automatic logic [WORD_BITS-1:0] minterm(
      input logic [CODE_BITS-1:0] code,
      input logic [WORD_BITS-1:0] a,
      input logic [WORD_BITS-1:0] b,
      input logic [WORD_BITS-1:0] c
   );
      logic [WORD_BITS-1:0] acc;
      logic [WORD_BITS-1:0] ta;
      logic [WORD_BITS-1:0] tb;
      logic [WORD_BITS-1:0] tc;
      logic [2:0]           sel;
      acc = '0;
      for (int i = 0; i < CODE_BITS; i++) begin
         sel = 3'(i);
         ta  = sel[2] ? a : ~a;
         tb  = sel[1] ? b : ~b;
         tc  = sel[0] ? c : ~c;
         if (code[i]) begin
            acc = acc | (ta & tb & tc);
         end
      end
      return acc;
   endfunction

endpackage

### sv/mab_req_if.sv
interface mab_req_if;
   logic                           valid;
   logic                           ready;
   logic [mab_pkg::WORD_BITS-1:0] a_word;
   logic [mab_pkg::WORD_BITS-1:0] b_word;
   logic [mab_pkg::WORD_BITS-1:0] c_word;

   modport source (output valid, a_word, b_word, c_word, input ready);
   modport sink   (input valid, a_word, b_word, c_word, output ready);
endinterface

### sv/mab_rsp_if.sv
interface mab_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mab_pkg::WORD_BITS-1:0] dest_word;
   logic [mab_pkg::ADDR_BITS-1:0] dest_address;
   logic                           row_done;
   logic                           area_done;

   modport source (output valid, dest_word, dest_address, row_done, area_done, input ready);
   modport sink   (input valid, dest_word, dest_address, row_done, area_done, output ready);
endinterface

### sv/minterm_area_blitter_top.sv
// Channel  Dir  Handshake     Item contents
// req      in   valid/ready   a_word, b_word, c_word
// rsp      out  valid/ready   dest_word, dest_address, row_done, area_done
// csr      in   csr_wr_en     csr_index, csr_wr_data (write only)
//
// One item per clock sustained while rsp is not stalled. An accepted req item passes
// the input register, then minterm logic into the result register, which drives rsp
// valid and the rest of the rsp item.
// Reset is synchronous and active high; CSRs, counters and valid flags reset, data words do not.
// A stall on rsp backs up into the input stage; req stays ready while that stage is
// empty or moving, so one item can sit waiting at each stage.
module minterm_area_blitter_top (
   input  logic                               clock,
   input  logic                               reset,
   mab_req_if.sink                            req,
   mab_rsp_if.source                          rsp,
   input  logic                               csr_wr_en,
   input  logic [mab_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mab_pkg::CSR_DATA_BITS-1:0] csr_wr_data
);
   import mab_pkg::*;

   cfg_type cfg;   // live register values
   seq_type tag;   // address, flags and A carry for the item on req
   logic    accept;

   // An item enters exactly when the input stage takes it; the sequencer
   // advances its counters, pointer and A carry on that same edge.
   assign accept = req.valid && req.ready;

   // Register file. Writes are to land only between areas, by the user; the block does not
   // enforce it. dest_start is taken at each area start, the other fields are read live.
   mab_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // Column/row counters, destination pointer and previous A word.
   // When both counters are zero the pointer reloads from dest_start and
   // the A carry is cleared before the word is tagged.
   mab_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .accept (accept),
      .a_word (req.a_word),
      .tag    (tag)
   );

   // Input register, barrel shift of A with carry, minterm, result register.
   mab_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .tag   (tag),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

### sv/mab_csr.sv
module mab_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [mab_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mab_pkg::CSR_DATA_BITS-1:0] csr_wr_data,
   output mab_pkg::cfg_type                   cfg
);
   import mab_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MINTERM_CODE: cfg_in.minterm_code = csr_wr_data[CODE_BITS-1:0];
            CSR_A_SHIFT:      cfg_in.a_shift      = csr_wr_data[SHIFT_BITS-1:0];
            CSR_WIDTH_WORDS:  cfg_in.width_words  = csr_wr_data[WIDTH_BITS-1:0];
            CSR_HEIGHT_ROWS:  cfg_in.height_rows  = csr_wr_data[HEIGHT_BITS-1:0];
            CSR_DEST_START:   cfg_in.dest_start   = csr_wr_data[ADDR_BITS-1:0];
            CSR_DEST_MODULO:  cfg_in.dest_modulo  = signed'(csr_wr_data[MODULO_BITS-1:0]);
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.minterm_code <= MINTERM_RESET;
         cfg_ff.a_shift      <= '0;
         cfg_ff.width_words  <= WIDTH_RESET;
         cfg_ff.height_rows  <= HEIGHT_RESET;
         cfg_ff.dest_start   <= '0;
         cfg_ff.dest_modulo  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/mab_seq.sv
`include "minterm_area_blitter_top_defines.svh"

module mab_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  mab_pkg::cfg_type               cfg,
   input  logic                           accept,
   input  logic [mab_pkg::WORD_BITS-1:0] a_word,
   output mab_pkg::seq_type               tag
);
   import mab_pkg::*;

   logic [COL_BITS-1:0]  col_ff,  col_in;
   logic [ROW_BITS-1:0]  row_ff,  row_in;
   logic [ADDR_BITS-1:0] ptr_ff,  ptr_in;
   logic [WORD_BITS-1:0] prev_ff, prev_in;

   logic                 area_start;
   logic [ADDR_BITS-1:0] ptr_cur;
   logic [ADDR_BITS-1:0] mod_ext;
   logic [ADDR_BITS-1:0] step;
   logic [COL_BITS-1:0]  last_col;
   logic [ROW_BITS-1:0]  last_row;
   logic                 row_end;
   logic                 area_end;

   always_comb begin
      area_start = (col_ff == '0) && (row_ff == '0);
      // a new area reloads the base and drops the A carry
      ptr_cur    = area_start ? {cfg.dest_start[ADDR_BITS-1:1], 1'b0} : ptr_ff;
      last_col   = cfg.width_words[COL_BITS-1:0] - COL_BITS'(1);
      last_row   = cfg.height_rows[ROW_BITS-1:0] - ROW_BITS'(1);
      row_end    = (col_ff == last_col);
      area_end   = row_end && (row_ff == last_row);
      mod_ext    = {{(ADDR_BITS-MODULO_BITS){cfg.dest_modulo[MODULO_BITS-1]}},
                    cfg.dest_modulo[MODULO_BITS-1:1], 1'b0};
      step       = row_end ? (mod_ext + ADDR_BITS'(2)) : ADDR_BITS'(2);

      tag.prev_a   = area_start ? '0 : prev_ff;
      tag.address  = ptr_cur;
      tag.row_end  = row_end;
      tag.area_end = area_end;

      col_in  = col_ff;
      row_in  = row_ff;
      ptr_in  = ptr_ff;
      prev_in = prev_ff;
      if (accept) begin
         ptr_in  = ptr_cur + step;
         prev_in = a_word;
         if (row_end) begin
            col_in = '0;
            row_in = area_end ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ptr_ff  <= '0;
         prev_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         ptr_ff  <= ptr_in;
         prev_ff <= prev_in;
      end
   end

   `MAB_ASSERT_NEXT(a_area_wraps, accept && area_end, (col_ff == '0) && (row_ff == '0), "area end did not clear counters")
   `MAB_ASSERT_NEXT(a_col_steps, accept && !row_end, col_ff == $past(col_ff) + COL_BITS'(1), "column count did not step")
   `MAB_ASSERT_NOW(a_ptr_even, !area_start, !ptr_ff[0], "destination pointer went odd")

endmodule

### sv/mab_datapath.sv
`include "minterm_area_blitter_top_defines.svh"

module mab_datapath (
   input  logic             clock,
   input  logic             reset,
   input  mab_pkg::cfg_type cfg,
   input  mab_pkg::seq_type tag,
   mab_req_if.sink          req,
   mab_rsp_if.source        rsp
);
   import mab_pkg::*;

   // input stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [WORD_BITS-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   seq_type              s1_tag_ff;

   // result stage
   logic                 out_valid_ff, out_valid_in;
   logic [WORD_BITS-1:0] out_word_ff;
   logic [ADDR_BITS-1:0] out_addr_ff;
   logic                 out_row_ff, out_area_ff;

   logic                 out_stage_ready;
   logic                 advance;
   logic                 in_accept;
   logic [WORD_BITS-1:0] word_in;

   always_comb begin
      out_stage_ready = !out_valid_ff || rsp.ready;
      advance         = s1_valid_ff && out_stage_ready;
      req.ready       = !s1_valid_ff || out_stage_ready;
      in_accept       = req.valid && req.ready;

      s1_valid_in  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

      word_in = minterm(cfg.minterm_code,
                        shift_a(s1_tag_ff.prev_a, s1_a_ff, cfg.a_shift),
                        s1_b_ff, s1_c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_a_ff   <= req.a_word;
         s1_b_ff   <= req.b_word;
         s1_c_ff   <= req.c_word;
         s1_tag_ff <= tag;
      end
      if (advance) begin
         out_word_ff <= word_in;
         out_addr_ff <= s1_tag_ff.address;
         out_row_ff  <= s1_tag_ff.row_end;
         out_area_ff <= s1_tag_ff.area_end;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.dest_word    = out_word_ff;
   assign rsp.dest_address = out_addr_ff;
   assign rsp.row_done     = out_row_ff;
   assign rsp.area_done    = out_area_ff;

   `MAB_ASSERT_NEXT(a_stage_moves, advance, out_valid_ff, "advanced item missing from result stage")
   `MAB_ASSERT_NEXT(a_stage_holds, s1_valid_ff && !out_stage_ready, s1_valid_ff, "stalled item dropped from input stage")
   `MAB_ASSERT_NOW(a_area_is_row, out_valid_ff && out_area_ff, out_row_ff, "area end without row end")

endmodule
